// ----- rtl/core/afrd_pkg.sv -----
// Package for the acknowledgement frame range decoder.
// Holds the request and result struct types and the result kind codes.
// Depends on nothing; used by ack_frame_range_decoder.
package afrd_pkg;

    // Field widths of the request and the result.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 62;
    localparam int VALUE_W = 64;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ECN    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TRUNC  = 2'd3;

    // Fixed offset between one range's start and the next range's end.
    localparam logic [VALUE_W-1:0] GAP_BIAS = 64'd2;

    // Index of the last ECN counter (ce).
    localparam logic [1:0] ECN_LAST = 2'd2;

    // One input request: a frame body byte and its framing flags.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              frame_start;
        logic              ecn_frame;
        logic              buffer_end;
    } t_in_item;

    // One decoded result.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value_low;
        logic [VALUE_W-1:0] value_high;
        logic               last_of_frame;
    } t_out_item;

endpackage

// ----- rtl/core/ack_frame_range_decoder.sv -----
// Acknowledgement frame range decoder: byte-serial variable-length integer
// decoder that emits header, range, ECN counter and truncation results.
// Depends on afrd_pkg.
// A byte's request is registered in the input register, then decoded into the
// result register. Throughput: one byte per cycle unless the result register is
// held full; the decode stage keeps all frame state.
// Reset (i_rst_n low, synchronous): both stages empty, decoder waits for a
// byte flagged frame_start; bytes without it are dropped silently.
module ack_frame_range_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  afrd_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output afrd_pkg::t_out_item o_out_item
);

    // Decoder phases.
    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_LARGE = 3'd1;
    localparam logic [2:0] PH_DELAY = 3'd2;
    localparam logic [2:0] PH_COUNT = 3'd3;
    localparam logic [2:0] PH_FIRST = 3'd4;
    localparam logic [2:0] PH_GAP   = 3'd5;
    localparam logic [2:0] PH_LEN   = 3'd6;
    localparam logic [2:0] PH_ECN   = 3'd7;

    localparam int IW = afrd_pkg::INDEX_W;
    localparam int VW = afrd_pkg::VALUE_W;

    // Pipeline registers.
    logic                r_in_valid;
    afrd_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    afrd_pkg::t_out_item r_out_item;

    // Decoder state.
    logic [2:0]    r_phase,        n_phase;
    logic [VW-1:0] r_acc,          n_acc;
    logic [2:0]    r_left,         n_left;
    logic [VW-1:0] r_largest,      n_largest;
    logic [IW-1:0] r_ranges_left,  n_ranges_left;
    logic [VW-1:0] r_prev_start,   n_prev_start;
    logic [VW-1:0] r_range_end,    n_range_end;
    logic [IW-1:0] r_range_number, n_range_number;
    logic [1:0]    r_ecn_number,   n_ecn_number;
    logic          r_has_ecn,      n_has_ecn;

    logic                out_free;
    logic                decode_fire;
    logic                n_res_valid;
    afrd_pkg::t_out_item n_res;

    // Handshake: the result register frees when empty or being taken.
    assign out_free    = !r_out_valid || i_out_ready;
    assign decode_fire = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || decode_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Decode of one byte against the frame state.
    always_comb begin
        logic [afrd_pkg::BYTE_W-1:0] b;
        logic                        start;
        logic [2:0]                  eff_phase;
        logic [2:0]                  eff_left;
        logic [VW-1:0]               v;
        logic                        done;

        b     = r_in_item.byte_value;
        start = r_in_item.frame_start;

        // A frame start clears the frame state before this byte is used.
        eff_phase      = start ? PH_LARGE : r_phase;
        eff_left       = start ? 3'd0 : r_left;
        n_has_ecn      = start ? r_in_item.ecn_frame : r_has_ecn;
        n_range_number = start ? '0 : r_range_number;
        n_ecn_number   = start ? 2'd0 : r_ecn_number;
        n_ranges_left  = start ? '0 : r_ranges_left;
        n_prev_start   = start ? '0 : r_prev_start;
        n_range_end    = r_range_end;
        n_largest      = r_largest;
        n_phase        = eff_phase;
        n_acc          = r_acc;
        n_left         = eff_left;
        n_res_valid    = 1'b0;
        n_res          = '0;

        // Variable-length integer assembly, most significant byte first.
        if (eff_left == 3'd0) begin
            n_left = 3'((4'b0001 << b[7:6]) - 4'b0001);
            n_acc  = {58'd0, b[5:0]};
        end else begin
            n_left = eff_left - 3'd1;
            n_acc  = {r_acc[VW-9:0], b};
        end
        v    = n_acc;
        done = (n_left == 3'd0);

        if (eff_phase == PH_WAIT) begin
            // No frame open: the byte is dropped with no state change.
            n_acc  = r_acc;
            n_left = r_left;
        end else begin
            if (done) begin
                case (eff_phase)
                    PH_LARGE: begin
                        n_largest = v;
                        n_phase   = PH_DELAY;
                    end
                    PH_DELAY: begin
                        n_res_valid      = 1'b1;
                        n_res.kind       = afrd_pkg::KIND_HEADER;
                        n_res.value_low  = v;
                        n_res.value_high = r_largest;
                        n_phase          = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_ranges_left = v[IW-1:0];
                        n_phase       = PH_FIRST;
                    end
                    PH_FIRST: begin
                        n_res_valid      = 1'b1;
                        n_res.kind       = afrd_pkg::KIND_RANGE;
                        n_res.value_high = r_largest;
                        n_res.value_low  = r_largest - v;
                        n_prev_start     = r_largest - v;
                        n_range_number   = IW'(1);
                        if (n_ranges_left == '0) begin
                            n_phase             = n_has_ecn ? PH_ECN : PH_WAIT;
                            n_res.last_of_frame = !n_has_ecn;
                        end else begin
                            n_phase = PH_GAP;
                        end
                    end
                    PH_GAP: begin
                        // Work out the next range's end as soon as the gap is known.
                        n_range_end = r_prev_start - v - afrd_pkg::GAP_BIAS;
                        n_phase     = PH_LEN;
                    end
                    PH_LEN: begin
                        n_res_valid      = 1'b1;
                        n_res.kind       = afrd_pkg::KIND_RANGE;
                        n_res.index      = r_range_number;
                        n_res.value_high = r_range_end;
                        n_res.value_low  = r_range_end - v;
                        n_prev_start     = r_range_end - v;
                        n_range_number   = r_range_number + IW'(1);
                        n_ranges_left    = r_ranges_left - IW'(1);
                        if (r_ranges_left == IW'(1)) begin
                            n_phase             = r_has_ecn ? PH_ECN : PH_WAIT;
                            n_res.last_of_frame = !r_has_ecn;
                        end else begin
                            n_phase = PH_GAP;
                        end
                    end
                    PH_ECN: begin
                        n_res_valid     = 1'b1;
                        n_res.kind      = afrd_pkg::KIND_ECN;
                        n_res.index     = {{(IW-2){1'b0}}, r_ecn_number};
                        n_res.value_low = v;
                        if (r_ecn_number >= afrd_pkg::ECN_LAST) begin
                            n_res.last_of_frame = 1'b1;
                            n_phase             = PH_WAIT;
                        end else begin
                            n_ecn_number = r_ecn_number + 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Buffer ran out before the frame closed: report truncation.
            if (r_in_item.buffer_end && (n_phase != PH_WAIT)) begin
                n_phase             = PH_WAIT;
                n_left              = 3'd0;
                n_res_valid         = 1'b1;
                n_res               = '0;
                n_res.kind          = afrd_pkg::KIND_TRUNC;
                n_res.last_of_frame = 1'b1;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= decode_fire && n_res_valid;
        end
        if (decode_fire && n_res_valid) begin
            r_out_item <= n_res;
        end
    end

    // Frame state update, once per decoded byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_WAIT;
            r_acc          <= '0;
            r_left         <= 3'd0;
            r_largest      <= '0;
            r_ranges_left  <= '0;
            r_prev_start   <= '0;
            r_range_end    <= '0;
            r_range_number <= '0;
            r_ecn_number   <= 2'd0;
            r_has_ecn      <= 1'b0;
        end else if (decode_fire) begin
            r_phase        <= n_phase;
            r_acc          <= n_acc;
            r_left         <= n_left;
            r_largest      <= n_largest;
            r_ranges_left  <= n_ranges_left;
            r_prev_start   <= n_prev_start;
            r_range_end    <= n_range_end;
            r_range_number <= n_range_number;
            r_ecn_number   <= n_ecn_number;
            r_has_ecn      <= n_has_ecn;
        end
    end

endmodule
